/* sv/kcpm_pkg.sv */
// Package for the keyfile CRC pool mixer: item types, codes, CRC step.
package kcpm_pkg;

    localparam int LEN_W = 21;
    localparam int CFG_W = 21;
    localparam int CFG_IDX_W = 2;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 21'h10_0000;
    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 21'd1;
    localparam logic [7:0] POOL_SIZE_RESET = 8'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd2;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_PASSWORD = 3'd1,
        OP_KEYFILE  = 3'd2,
        OP_END      = 3'd3,
        OP_READ     = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_READ     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_SHORT    = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
        logic [6:0] pool_index;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
    } rsp_t;

    // Reflected CRC-32, one byte, bit at a time.
    function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* sv/keyfile_crc_pool_mixer_unit.sv */
// Keyfile CRC pool mixer: CRC-32 of keyfile bytes added into a banked byte pool.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  req     | in        | req_valid / req_ready  | opcode, data_byte, pool_index
//  rsp     | out       | rsp_valid / rsp_ready  | read_data, status
//  cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
//  One item per cycle while req_ready is high. A keyfile byte whose four pool
//  positions wrap inside a pool size of five or more that is not a multiple
//  of four takes two passes through the four byte banks (one write port each).
//  Results pass the bank read, then the update stage, before they leave; a
//  three-entry output queue absorbs rsp stalls.
//  Reset clears the pool at once through per-entry valid bits; no sweep.
//  req_ready drops only for the second pass or when the output queue, counting
//  a result now in the update stage, is full.
module keyfile_crc_pool_mixer_unit
    import kcpm_pkg::*;
#(
    parameter int POOL_DEPTH = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int PW = AW + 1;
    localparam int RW = AW - 2;
    localparam int ROWS = (POOL_DEPTH + 3) / 4;

    typedef logic [RW-1:0] row_t;
    typedef logic [PW-1:0] pos_t;

    // One pass over the four banks.
    typedef struct packed {
        logic [3:0]       en;
        row_t [3:0]       row;
        logic [3:0][7:0]  addend;
        logic             replace;
        logic             clear;
        logic             has_res;
        logic             is_read;
        logic [1:0]       read_bank;
        logic             in_range;
        logic [1:0]       status;
    } mop_t;

    function automatic pos_t pos_step(pos_t p, pos_t s);
        pos_t n;
        n = p + PW'(1);
        return (n >= s) ? '0 : n;
    endfunction

    // configuration
    pos_t             size_reg;
    logic [LEN_W-1:0] max_len_reg;
    logic [LEN_W-1:0] min_len_reg;
    pos_t             size_cfg;

    // keyfile state
    logic [31:0]      crc_reg;
    logic [AW-1:0]    pos_reg;
    logic [LEN_W-1:0] count_reg;
    logic             capped_reg;

    // pipeline
    logic             pend_reg;
    mop_t             hold_reg;
    logic             s1_valid_reg;
    mop_t             s1_reg;
    logic [3:0]       fw_en_reg;
    row_t [3:0]       fw_row_reg;
    logic [3:0][7:0]  fw_data_reg;
    logic [POOL_DEPTH-1:0] valid_reg;

    // output queue
    rsp_t             fifo_reg [3];
    logic [1:0]       head_reg;
    logic [1:0]       tail_reg;
    logic [1:0]       occ_reg;

    logic             accept;
    logic [31:0]      crc_next;
    logic [31:0]      mix;
    pos_t [3:0]       q;
    pos_t             pos_next;
    logic [3:0]       wrap;
    logic [3:0]       after;
    logic             split;
    logic             keyfile_go;
    logic             useful;
    logic [AW-1:0]    idx_l;
    logic             idx_ok;
    mop_t             s0_mu;
    mop_t             mu_b;
    logic [LEN_W-1:0] count_next;

    row_t [3:0]       raddr;
    logic [3:0][7:0]  rd;
    logic [3:0][7:0]  old;
    logic [3:0][7:0]  wdata;
    logic [3:0]       we;
    logic [3:0][AW-1:0] lg;

    logic             push;
    logic             pop;
    rsp_t             push_item;
    logic             s1_res;

    // ---------------- configuration ----------------
    always_comb
    begin
        if (cfg_data[7:0] == 8'd0 || int'(cfg_data[7:0]) > POOL_DEPTH)
            size_cfg = PW'(POOL_DEPTH);
        else
            size_cfg = PW'(cfg_data[7:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= PW'(POOL_SIZE_RESET);
            max_len_reg <= MAX_LEN_RESET;
            min_len_reg <= MIN_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POOL_SIZE: size_reg <= size_cfg;
                CFG_MAX_LEN:   max_len_reg <= cfg_data[LEN_W-1:0];
                CFG_MIN_LEN:   min_len_reg <= cfg_data[LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------- stage 0: decode, CRC, positions ----------------
    assign accept     = req_valid && req_ready;
    assign crc_next   = crc_byte(crc_reg, req.data_byte);
    assign mix        = ~crc_next;
    assign count_next = count_reg + LEN_W'(1);
    assign keyfile_go = (req.opcode == OP_KEYFILE) && !capped_reg;
    assign idx_l      = AW'(req.pool_index);
    assign idx_ok     = int'(req.pool_index) < POOL_DEPTH;

    always_comb
    begin
        q[0] = ({1'b0, pos_reg} >= size_reg) ? '0 : {1'b0, pos_reg};
        for (int k = 1; k < 4; k++)
        begin
            q[k] = pos_step(q[k-1], size_reg);
        end
        pos_next = pos_step(q[3], size_reg);
        wrap[0]  = 1'b0;
        after[0] = 1'b0;
        for (int k = 1; k < 4; k++)
        begin
            wrap[k]  = (q[k] == '0);
            after[k] = after[k-1] | wrap[k];
        end
    end

    // A wrap with a size that is not a multiple of four lands two positions
    // in one bank at different rows: needs a second pass.
    assign split = (size_reg >= PW'(4)) && (size_reg[1:0] != 2'b00) && (|wrap);

    always_comb
    begin
        s0_mu  = '0;
        mu_b   = '0;
        useful = 1'b1;
        case (req.opcode)
            OP_CLEAR:
            begin
                s0_mu.clear = 1'b1;
            end
            OP_PASSWORD:
            begin
                if (idx_ok)
                begin
                    s0_mu.en[idx_l[1:0]]     = 1'b1;
                    s0_mu.row[idx_l[1:0]]    = idx_l[AW-1:2];
                    s0_mu.addend[idx_l[1:0]] = req.data_byte;
                    s0_mu.replace            = 1'b1;
                end
            end
            OP_KEYFILE:
            begin
                useful = !capped_reg;
                for (int k = 0; k < 4; k++)
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        if (q[k][1:0] == 2'(b))
                        begin
                            if (split && after[k])
                            begin
                                mu_b.en[b]     = 1'b1;
                                mu_b.row[b]    = q[k][AW-1:2];
                                mu_b.addend[b] = mu_b.addend[b] + mix[31-8*k -: 8];
                            end
                            else
                            begin
                                s0_mu.en[b]     = 1'b1;
                                s0_mu.row[b]    = q[k][AW-1:2];
                                s0_mu.addend[b] = s0_mu.addend[b] + mix[31-8*k -: 8];
                            end
                        end
                    end
                end
            end
            OP_END:
            begin
                s0_mu.has_res = 1'b1;
                s0_mu.status  = (count_reg < min_len_reg) ? ST_SHORT : ST_ACCEPTED;
            end
            OP_READ:
            begin
                s0_mu.has_res   = 1'b1;
                s0_mu.is_read   = 1'b1;
                s0_mu.read_bank = idx_l[1:0];
                s0_mu.in_range  = idx_ok;
                s0_mu.status    = ST_READ;
                for (int b = 0; b < 4; b++)
                begin
                    s0_mu.row[b] = idx_l[AW-1:2];
                end
            end
            default:
            begin
                useful = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= '1;
            pos_reg    <= '0;
            count_reg  <= '0;
            capped_reg <= 1'b0;
        end
        else if (accept)
        begin
            case (req.opcode)
                OP_CLEAR, OP_END:
                begin
                    crc_reg    <= '1;
                    pos_reg    <= '0;
                    count_reg  <= '0;
                    capped_reg <= 1'b0;
                end
                OP_KEYFILE:
                begin
                    if (!capped_reg)
                    begin
                        crc_reg    <= crc_next;
                        pos_reg    <= pos_next[AW-1:0];
                        count_reg  <= count_next;
                        capped_reg <= (count_next >= max_len_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: bank read data, add, write back ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            fw_en_reg    <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            pend_reg     <= accept && keyfile_go && split;
            s1_valid_reg <= pend_reg || (accept && useful);
            fw_en_reg    <= we;
            if (s1_valid_reg && s1_reg.clear)
            begin
                valid_reg <= '0;
            end
            else
            begin
                for (int b = 0; b < 4; b++)
                begin
                    if (we[b])
                        valid_reg[lg[b]] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= pend_reg ? hold_reg : s0_mu;
        hold_reg    <= mu_b;
        fw_row_reg  <= s1_reg.row;
        fw_data_reg <= wdata;
    end

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            raddr[b] = pend_reg ? hold_reg.row[b] : s0_mu.row[b];
            lg[b]    = {s1_reg.row[b], 2'(b)};
            // write of the previous cycle is not yet visible at the read port
            if (!valid_reg[lg[b]])
                old[b] = 8'd0;
            else if (fw_en_reg[b] && fw_row_reg[b] == s1_reg.row[b])
                old[b] = fw_data_reg[b];
            else
                old[b] = rd[b];
            wdata[b] = s1_reg.replace ? s1_reg.addend[b] : old[b] + s1_reg.addend[b];
            we[b]    = s1_valid_reg && s1_reg.en[b];
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        kcpm_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (we[g]),
            .waddr (s1_reg.row[g]),
            .wdata (wdata[g]),
            .raddr (raddr[g]),
            .rdata (rd[g])
        );
    end

    // ---------------- output queue ----------------
    assign s1_res = s1_valid_reg && s1_reg.has_res;
    assign push   = s1_res;
    assign pop    = rsp_valid && rsp_ready;

    always_comb
    begin
        push_item.status    = s1_reg.status;
        push_item.read_data = (s1_reg.is_read && s1_reg.in_range) ?
                              old[s1_reg.read_bank] : 8'd0;
    end

    assign rsp_valid = (occ_reg != 2'd0);
    assign rsp       = fifo_reg[head_reg];
    // a result in stage 1 always lands in the queue next edge
    assign req_ready = !pend_reg && ((3'(occ_reg) + 3'(s1_res)) < 3'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            if (push)
                tail_reg <= (tail_reg == 2'd2) ? 2'd0 : tail_reg + 2'd1;
            if (pop)
                head_reg <= (head_reg == 2'd2) ? 2'd0 : head_reg + 2'd1;
            occ_reg <= occ_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[tail_reg] <= push_item;
    end

    // ---------------- assertions ----------------
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_res |-> (occ_reg < 2'd3))
        else $error("result arrives at a full output queue");

    a_split_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && keyfile_go && split) |=> (pend_reg && !req_ready))
        else $error("second bank pass not taken after a wrapping keyfile byte");

    a_pend_once: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> !pend_reg)
        else $error("second pass lasted more than one cycle");

    a_clear_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_reg.clear) |=> (valid_reg == '0))
        else $error("pool not empty after clear");

endmodule

/* sv/kcpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kcpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
